[rtl/pqt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pqt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int PRI_W        = 8;
  localparam int PID_W        = 16;
  localparam int TAG_W        = 16;

  // input mode codes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [PID_W-1:0] pid;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    RES_STORED,
    RES_FULL,
    RES_EMPTY,
    RES_POP
  } res_t;

  typedef struct packed {
    logic load;
    logic rd_step;
    logic shift_wr;
    logic new_wr;
    logic new_at_head;
    logic cnt_inc;
    logic pop;
    logic out_load;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic below;
    logic idx_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/pqt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pqt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_mode,
  output logic             in_ready,
  input  wire pqt_pkg::sts_t sts,
  output pqt_pkg::cmd_t    cmd
);
  import pqt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_DEQ,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.res   = res_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_mode == MODE_DEQ) begin
            if (sts.empty) begin
              res_nxt   = RES_EMPTY;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_DEQ;
            end
          end else if (sts.full) begin
            res_nxt   = RES_FULL;
            state_nxt = S_RESP;
          end else if (sts.empty) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.below) begin
          cmd.shift_wr = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_step = 1'b1;
          end
        end else begin
          cmd.new_wr  = 1'b1;
          cmd.cnt_inc = 1'b1;
          res_nxt     = RES_STORED;
          state_nxt   = S_RESP;
        end
      end
      S_PLACE: begin
        cmd.new_wr      = 1'b1;
        cmd.new_at_head = 1'b1;
        cmd.cnt_inc     = 1'b1;
        res_nxt         = RES_STORED;
        state_nxt       = S_RESP;
      end
      S_DEQ: begin
        cmd.pop   = 1'b1;
        res_nxt   = RES_POP;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RES_STORED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/pqt_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module pqt_dpath #(
  parameter int CAPACITY = pqt_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pqt_pkg::cmd_t             cmd,
  output pqt_pkg::sts_t                  sts,
  input  wire logic                      in_mode,
  input  wire logic [pqt_pkg::PRI_W-1:0] in_priority_req,
  input  wire logic [pqt_pkg::PID_W-1:0] in_process_id,
  input  wire logic [pqt_pkg::TAG_W-1:0] in_item_tag,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_accepted,
  output logic                           out_was_empty,
  output logic                           out_was_full,
  output logic [pqt_pkg::PRI_W-1:0]      out_priority,
  output logic [pqt_pkg::PID_W-1:0]      out_process_id,
  output logic [pqt_pkg::TAG_W-1:0]      out_item_tag
);
  import pqt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CAP_EXT = (AW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST    = AW'(CAPACITY - 1);

  entry_t mem [CAPACITY];

  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  entry_t        new_r;
  entry_t        rdata_r;
  logic          out_valid_r;

  logic [CW-1:0] count_dec;
  logic [AW-1:0] cnt_m1, idx_m1, idx_p1, rd_l, wr_l;
  entry_t        wr_data;

  // logical slot to ring position
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, hd} + {1'b0, l};
    if (s >= CAP_EXT) begin
      s = s - CAP_EXT;
    end
    return s[AW-1:0];
  endfunction

  assign count_dec = count_r - 1'b1;
  assign cnt_m1    = count_dec[AW-1:0];
  assign idx_m1    = idx_r - 1'b1;
  assign idx_p1    = idx_r + 1'b1;
  assign rd_l      = cmd.load ? ((in_mode == MODE_DEQ) ? '0 : cnt_m1) : idx_m1;
  assign wr_l      = cmd.new_at_head ? '0 : idx_p1;
  assign wr_data   = cmd.shift_wr ? rdata_r : new_r;

  always_comb begin
    sts.full     = (count_r == CAP_CNT);
    sts.empty    = (count_r == '0);
    sts.below    = (rdata_r.pri < new_r.pri) ||
                   ((rdata_r.pri == new_r.pri) && (rdata_r.pid < new_r.pid));
    sts.idx_zero = (idx_r == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.rd_step) begin
      rdata_r <= mem[phys(head_r, rd_l)];
    end
    if (cmd.shift_wr || cmd.new_wr) begin
      mem[phys(head_r, wr_l)] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_r.pri <= in_priority_req;
      new_r.pid <= in_process_id;
      new_r.tag <= in_item_tag;
      idx_r     <= cnt_m1;
    end else if (cmd.rd_step) begin
      idx_r <= idx_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.pop) begin
        count_r <= count_dec;
        head_r  <= (head_r == LAST) ? '0 : head_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accepted   <= (cmd.res == RES_STORED) || (cmd.res == RES_POP);
      out_was_empty  <= (cmd.res == RES_EMPTY);
      out_was_full   <= (cmd.res == RES_FULL);
      out_priority   <= (cmd.res == RES_POP) ? rdata_r.pri : '0;
      out_process_id <= (cmd.res == RES_POP) ? rdata_r.pid : '0;
      out_item_tag   <= (cmd.res == RES_POP) ? rdata_r.tag : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/priority_queue_with_tiebreak.sv]
// Bounded priority queue of (priority, process, tag) entries kept sorted in a ring
// memory of CAPACITY slots: higher priority leaves first, then the larger process
// number, then arrival order. One transaction is handled at a time. An enqueue walks
// the memory from the tail one slot per cycle (one read and one write port), moving
// up each stored entry that ranks below the new one (at most CAPACITY - 1 of them).
// Full and empty cases go straight to the result. The result waits in an output
// register, and a new transaction is taken once the previous result has been
// loaded there.
`timescale 1ns / 1ps
`default_nettype none

module priority_queue_with_tiebreak #(
  parameter int CAPACITY = pqt_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_mode,
  input  wire logic [pqt_pkg::PRI_W-1:0] in_priority_req,
  input  wire logic [pqt_pkg::PID_W-1:0] in_process_id,
  input  wire logic [pqt_pkg::TAG_W-1:0] in_item_tag,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_accepted,
  output logic                           out_was_empty,
  output logic                           out_was_full,
  output logic [pqt_pkg::PRI_W-1:0]      out_priority,
  output logic [pqt_pkg::PID_W-1:0]      out_process_id,
  output logic [pqt_pkg::TAG_W-1:0]      out_item_tag
);
  import pqt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pqt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pqt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_priority_req (in_priority_req),
    .in_process_id   (in_process_id),
    .in_item_tag     (in_item_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_was_empty   (out_was_empty),
    .out_was_full    (out_was_full),
    .out_priority    (out_priority),
    .out_process_id  (out_process_id),
    .out_item_tag    (out_item_tag)
  );

  // exactly one outcome flag per result
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_accepted, out_was_empty, out_was_full}))
    else $error("result carries other than one outcome flag");

  // one transaction in flight
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while previous transaction in progress");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.full && sts.empty))
    else $error("queue reports full and empty together");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.shift_wr && cmd.new_wr))
    else $error("two memory writes in one cycle");

  // only a dequeue empties a slot with a popped result
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (cmd.res == RES_POP))
    else $error("pop not followed by a dequeue result");

endmodule

`default_nettype wire
